>>> hdl/fitp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fitp_pkg
// Shared types, constants and binary32 arithmetic helpers for the
// float-indexed table interpolator.
// ----------------------------------------------------------------------------
package fitp_pkg;

  // defaults for the top-level parameters
  localparam int FRACTION_BITS_DEF = 5;
  localparam int TABLE_DEPTH_DEF   = 512;
  localparam int QUEUE_DEPTH       = 4;

  localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;  // 1.0
  localparam logic [31:0] FP_TWO      = 32'h4000_0000;  // 2.0
  localparam logic [31:0] CANON_NAN   = 32'h7FC0_0000;
  localparam int          MANT_BITS   = 23;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } op_e;

  // Unrounded intermediate: value = (man / 2^48) * 2^(expo - 127)
  typedef struct packed {
    logic               nan;
    logic               inf;
    logic               sgn;
    logic signed [11:0] expo;
    logic [49:0]        man;
  } fp_raw_t;

  // Exact product of two binary32 operands, before rounding
  function automatic fp_raw_t fp_mul_pre(input logic [31:0] a, input logic [31:0] b);
    logic [7:0]  ea;
    logic [7:0]  eb;
    logic [23:0] ma;
    logic [23:0] mb;
    logic [47:0] p;
    logic        a_nan;
    logic        b_nan;
    logic        a_inf;
    logic        b_inf;
    logic        a_zero;
    logic        b_zero;
    fp_raw_t     r;
    ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma     = {|a[30:23], a[22:0]};
    mb     = {|b[30:23], b[22:0]};
    a_nan  = (&a[30:23]) && (|a[22:0]);
    b_nan  = (&b[30:23]) && (|b[22:0]);
    a_inf  = (&a[30:23]) && !(|a[22:0]);
    b_inf  = (&b[30:23]) && !(|b[22:0]);
    a_zero = !(|a[30:0]);
    b_zero = !(|b[30:0]);
    p      = ma * mb;
    r.sgn  = a[31] ^ b[31];
    r.nan  = a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
    r.inf  = a_inf | b_inf;
    r.expo = $signed({4'b0000, ea}) + $signed({4'b0000, eb}) - 12'sd127;
    r.man  = {p, 2'b00};
    return r;
  endfunction

  // Aligned sum of two binary32 operands, before normalising and rounding
  function automatic fp_raw_t fp_add_pre(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] big;
    logic [31:0] sml;
    logic [7:0]  el;
    logic [7:0]  es;
    logic [7:0]  d;
    logic [49:0] ml;
    logic [49:0] ms;
    logic [49:0] msx;
    logic [49:0] mask;
    logic [49:0] m;
    logic        a_nan;
    logic        b_nan;
    logic        a_inf;
    logic        b_inf;
    fp_raw_t     r;
    a_nan = (&a[30:23]) && (|a[22:0]);
    b_nan = (&b[30:23]) && (|b[22:0]);
    a_inf = (&a[30:23]) && !(|a[22:0]);
    b_inf = (&b[30:23]) && !(|b[22:0]);
    if (b[30:0] > a[30:0]) begin
      big = b;
      sml = a;
    end else begin
      big = a;
      sml = b;
    end
    el   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d    = el - es;
    ml   = {1'b0, |big[30:23], big[22:0], 25'd0};
    ms   = {1'b0, |sml[30:23], sml[22:0], 25'd0};
    mask = '0;
    if (d >= 8'd50) begin
      msx = {49'd0, |ms};
    end else begin
      mask = (50'd1 << d[5:0]) - 50'd1;
      msx  = ms >> d[5:0];
      msx[0] = msx[0] | (|(ms & mask));
    end
    if (big[31] == sml[31]) begin
      m = ml + msx;
    end else begin
      m = ml - msx;
    end
    r.nan  = a_nan | b_nan | (a_inf & b_inf & (a[31] != b[31]));
    r.inf  = a_inf | b_inf;
    r.expo = $signed({4'b0000, el});
    r.man  = m;
    // exact cancellation rounds to +0 unless both operands are -0
    if (r.inf) begin
      r.sgn = a_inf ? a[31] : b[31];
    end else if (m == 50'd0) begin
      r.sgn = a[31] & b[31];
    end else begin
      r.sgn = big[31];
    end
    return r;
  endfunction

  // Normalise and round to nearest even, with subnormal and overflow handling
  function automatic logic [31:0] fp_round(input fp_raw_t r);
    logic [5:0]         lz;
    logic               found;
    logic [49:0]        nm;
    logic [49:0]        sh;
    logic [49:0]        mask;
    logic signed [11:0] e2;
    logic [11:0]        amt;
    logic [7:0]         ef;
    logic [30:0]        rs;
    logic               g;
    logic               st;
    logic [31:0]        res;
    lz    = '0;
    found = 1'b0;
    for (int i = 49; i >= 0; i--) begin
      if (!found && r.man[i]) begin
        lz    = 6'(49 - i);
        found = 1'b1;
      end
    end
    nm   = r.man << lz;
    e2   = r.expo + 12'sd1 - $signed({6'b000000, lz});
    amt  = 12'(12'sd1 - e2);
    mask = '0;
    sh   = nm;
    ef   = e2[7:0];
    if (e2 <= 12'sd0) begin
      ef = 8'd0;
      if (amt >= 12'd50) begin
        sh = 50'd1;
      end else begin
        mask  = (50'd1 << amt[5:0]) - 50'd1;
        sh    = nm >> amt[5:0];
        sh[0] = sh[0] | (|(nm & mask));
      end
    end
    g   = sh[25];
    st  = |sh[24:0];
    rs  = {ef, sh[48:26]} + {30'd0, g & (st | sh[26])};
    res = {r.sgn, rs};
    if (r.nan) begin
      res = CANON_NAN;
    end else if (r.inf || (e2 >= 12'sd255 && r.man != 50'd0)) begin
      res = {r.sgn, 8'hFF, 23'd0};
    end else if (r.man == 50'd0) begin
      res = {r.sgn, 31'd0};
    end
    return res;
  endfunction

endpackage

>>> hdl/fitp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fitp_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while the read enable is low.
// ----------------------------------------------------------------------------
module fitp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/fitp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fitp_front
// Accepts beats, classifies writes and evaluations, and computes
// x = r*r*scale + 2.0, the table index and dx = x - node in a nine-stage
// pipeline. Finished items are pushed into the queue in order.
// ----------------------------------------------------------------------------
module fitp_front #(
  parameter int FRACTION_BITS = fitp_pkg::FRACTION_BITS_DEF,
  parameter int TABLE_DEPTH   = fitp_pkg::TABLE_DEPTH_DEF,
  localparam int AW = $clog2(TABLE_DEPTH),
  localparam int QW = 1 + 1 + AW + 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          op_i,
  input  logic [8:0]    entry_index_i,
  input  logic [31:0]   entry_value_i,
  input  logic [31:0]   entry_slope_i,
  input  logic [31:0]   radius_i,
  input  logic [31:0]   scale_i,
  output logic          push_o,
  output logic [QW-1:0] push_data_o,
  input  logic          q_full_i
);

  localparam int NS   = 9;
  localparam int DROP = fitp_pkg::MANT_BITS - FRACTION_BITS;

  typedef struct packed {
    fitp_pkg::op_e     op;
    logic              we;
    logic [AW-1:0]     addr;
    logic [31:0]       val;    // entry value, or node bits for an evaluation
    logic [31:0]       slope;
    logic [31:0]       fv;     // working binary32 value
    fitp_pkg::fp_raw_t raw;
  } stage_t;

  typedef struct packed {
    fitp_pkg::op_e op;
    logic          we;
    logic [AW-1:0] addr;
    logic [31:0]   a;
    logic [31:0]   b;
  } qent_t;

  stage_t          st_q [NS];
  stage_t          st_d [NS];
  logic [NS-1:0]   vld_q;
  logic [NS-1:0]   vld_d;
  logic            adv;
  logic [31:0]     idx32;
  logic [31:0]     xsh;
  qent_t           qent;

  // whole pipeline holds while the last stage cannot push
  assign adv        = !(vld_q[NS-1] && q_full_i);
  assign in_ready_o = adv;
  assign idx32      = 32'(entry_index_i);

  // per-stage datapath
  always_comb begin
    xsh          = '0;
    st_d[0].op   = fitp_pkg::op_e'(op_i);
    st_d[0].we   = (op_i == fitp_pkg::OP_WRITE) && (idx32 < 32'(TABLE_DEPTH));
    st_d[0].addr = idx32[AW-1:0];
    st_d[0].val  = entry_value_i;
    st_d[0].slope = entry_slope_i;
    st_d[0].fv   = radius_i;
    st_d[0].raw  = '0;
    for (int k = 1; k < NS; k++) begin
      st_d[k] = st_q[k-1];
    end
    st_d[1].raw = fitp_pkg::fp_mul_pre(st_q[0].fv, st_q[0].fv);
    st_d[2].fv  = fitp_pkg::fp_round(st_q[1].raw);
    st_d[3].raw = fitp_pkg::fp_mul_pre(st_q[2].fv, scale_i);
    st_d[4].fv  = fitp_pkg::fp_round(st_q[3].raw);
    st_d[5].raw = fitp_pkg::fp_add_pre(st_q[4].fv, fitp_pkg::FP_TWO);
    st_d[6].fv  = fitp_pkg::fp_round(st_q[5].raw);
    // index and node from x
    if (st_q[5].op == fitp_pkg::OP_EVAL) begin
      xsh          = st_d[6].fv >> DROP;
      st_d[6].addr = xsh[AW-1:0];
      st_d[6].val  = xsh << DROP;
    end
    st_d[7].raw = fitp_pkg::fp_add_pre(st_q[6].fv, {~st_q[6].val[31], st_q[6].val[30:0]});
    st_d[8].fv  = fitp_pkg::fp_round(st_q[7].raw);
  end

  assign vld_d = {vld_q[NS-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q <= st_d;
    end
  end

  // queue entry: dx for evaluations, the value for writes
  always_comb begin
    qent.op   = st_q[NS-1].op;
    qent.we   = st_q[NS-1].we;
    qent.addr = st_q[NS-1].addr;
    qent.a    = (st_q[NS-1].op == fitp_pkg::OP_EVAL) ? st_q[NS-1].fv : st_q[NS-1].val;
    qent.b    = st_q[NS-1].slope;
  end

  assign push_o      = vld_q[NS-1] && adv;
  assign push_data_o = qent;

endmodule

>>> hdl/fitp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fitp_queue
// Short first-in first-out queue between the front and back pipelines.
// ----------------------------------------------------------------------------
module fitp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = fitp_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q;
  logic [PW-1:0]    wr_d;
  logic [PW-1:0]    rd_q;
  logic [PW-1:0]    rd_d;
  logic [PW:0]      cnt_q;
  logic [PW:0]      cnt_d;

  // pointer and fill count update
  always_comb begin
    wr_d  = push_i ? PW'(wr_q + 1'b1) : wr_q;
    rd_d  = pop_i ? PW'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_q];
  assign full_o  = (cnt_q == (PW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);

`ifndef SYNTHESIS
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue pushed while full");
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue popped while empty");
  a_count_up : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count did not follow a lone push");
`endif

endmodule

>>> hdl/fitp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fitp_back
// Pops queued items, writes or reads the node table, and forms
// value + dx*slope in a five-stage pipeline ending in the output register.
// ----------------------------------------------------------------------------
module fitp_back #(
  parameter int TABLE_DEPTH = fitp_pkg::TABLE_DEPTH_DEF,
  localparam int AW = $clog2(TABLE_DEPTH),
  localparam int QW = 1 + 1 + AW + 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [QW-1:0] head_i,
  input  logic          q_empty_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [31:0]   out_data_o
);

  typedef struct packed {
    fitp_pkg::op_e op;
    logic          we;
    logic [AW-1:0] addr;
    logic [31:0]   a;
    logic [31:0]   b;
  } qent_t;

  qent_t             head;
  logic              adv;
  logic              pop;
  logic              is_eval;
  logic [63:0]       rdata;

  logic              v1_q;
  logic [31:0]       dx1_q;
  logic              v2_q;
  logic [31:0]       val2_q;
  fitp_pkg::fp_raw_t raw2_q;
  logic              v3_q;
  logic [31:0]       val3_q;
  logic [31:0]       prod3_q;
  logic              v4_q;
  fitp_pkg::fp_raw_t raw4_q;
  logic              out_v_q;
  logic [31:0]       out_q;

  assign head    = head_i;
  assign adv     = !(out_v_q && !out_ready_i);
  assign pop     = !q_empty_i && adv;
  assign pop_o   = pop;
  assign is_eval = (head.op == fitp_pkg::OP_EVAL);

  // node table, laid out as {slope, value}
  fitp_ram #(
    .WIDTH (64),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (pop && head.we),
    .waddr_i (head.addr),
    .wdata_i ({head.b, head.a}),
    .re_i    (pop && is_eval),
    .raddr_i (head.addr),
    .rdata_o (rdata)
  );

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      v1_q    <= pop && is_eval;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      out_v_q <= v4_q;
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx1_q   <= head.a;
      val2_q  <= rdata[31:0];
      raw2_q  <= fitp_pkg::fp_mul_pre(dx1_q, rdata[63:32]);
      val3_q  <= val2_q;
      prod3_q <= fitp_pkg::fp_round(raw2_q);
      raw4_q  <= fitp_pkg::fp_add_pre(val3_q, prod3_q);
      out_q   <= fitp_pkg::fp_round(raw4_q);
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

>>> hdl/float_indexed_table_interpolator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_indexed_table_interpolator_unit
// Piecewise-linear table interpolation in binary32: write beats load
// (value, slope) entries, evaluate beats return value + dx*slope at
// x = r*r*scale + 2.0.
//
//   channel   direction  signals                     contents
//   s_axis    in         tvalid tready tdata tuser   write or evaluate item
//   m_axis    out        tvalid tready tdata         interpolated result
//   cfg       in         valid ready data            radius_sq_scale
//
// One beat is accepted per cycle while s_axis_tready is high. An evaluation
// passes through the front stages, the queue and the five back stages
// before m_axis_tvalid rises with its result.
// The table memory port is used once per beat, for a write or a read.
// Reset clears the pipeline valids, the queue and sets the scale to 1.0;
// the table holds no reset value.
// A stalled output freezes the back end; the front end keeps filling the
// four-entry queue and drops s_axis_tready once the queue is full and the
// last front stage holds a beat.
// ----------------------------------------------------------------------------
module float_indexed_table_interpolator_unit #(
  parameter int FRACTION_BITS = fitp_pkg::FRACTION_BITS_DEF,
  parameter int TABLE_DEPTH   = fitp_pkg::TABLE_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [8:0] entry_index, [40:9] entry_value, [72:41] entry_slope,
  // [104:73] radius, [111:105] zero
  input  logic [111:0] s_axis_tdata,
  // [0] operation
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] force_over_r
  output logic [31:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [31:0]  cfg_data_i
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int QW = 1 + 1 + AW + 64;

  logic [31:0]   scale_q;
  logic          push;
  logic [QW-1:0] push_data;
  logic [QW-1:0] head;
  logic          q_full;
  logic          q_empty;
  logic          pop;

  // scale register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= fitp_pkg::SCALE_RESET;
    end else if (cfg_valid_i) begin
      scale_q <= cfg_data_i;
    end
  end

  fitp_front #(
    .FRACTION_BITS (FRACTION_BITS),
    .TABLE_DEPTH   (TABLE_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .op_i          (s_axis_tuser),
    .entry_index_i (s_axis_tdata[8:0]),
    .entry_value_i (s_axis_tdata[40:9]),
    .entry_slope_i (s_axis_tdata[72:41]),
    .radius_i      (s_axis_tdata[104:73]),
    .scale_i       (scale_q),
    .push_o        (push),
    .push_data_o   (push_data),
    .q_full_i      (q_full)
  );

  fitp_queue #(
    .WIDTH (QW),
    .DEPTH (fitp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .pop_i   (pop),
    .data_o  (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  fitp_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the float-indexed table interpolator. Table
// loads and radius evaluations are streamed in bursts and checked against
// an in-bench binary32 predictor (round to nearest even, one rounding per
// operation) across several radius_sq_scale settings.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DROP = fitp_pkg::MANT_BITS - fitp_pkg::FRACTION_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct {
    fitp_pkg::op_e op;
    logic [8:0]    idx;
    logic [31:0]   value;
    logic [31:0]   slope;
    logic [31:0]   radius;
    logic [31:0]   force_exp;
  } beat_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [31:0]  m_axis_tdata;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [31:0]  cfg_data_i;

  float_indexed_table_interpolator_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // bench state
  beat_t       pending_beats[$];
  logic [31:0] force_queue[$];
  logic [31:0] scale_mdl;
  logic [31:0] val_mdl[512];
  logic [31:0] slope_mdl[512];
  bit          loaded[512];
  int          n_errors;
  int          idle_cycles;
  int          gap_left;
  int          burst_left;
  int          hold_left;
  int          rx_mode_left;
  int          rx_mode;
  int          results_seen;
  bit          long_hold_done;
  bit          s_taken;

  // ---------------------------------------------------------------- binary32
  // Round a nonzero magnitude m * 2^e to binary32, nearest even
  function automatic logic [31:0] f32_round(logic sgn, logic [63:0] m, int e);
    int          p;
    int          be;
    int          sh;
    logic [63:0] mant;
    logic        g;
    logic        st;
    p = 0;
    g = 1'b0;
    st = 1'b0;
    for (int i = 0; i < 64; i++) if (m[i]) p = i;
    be = p - 23 + e + 150;
    if (be < 1) be = 1;
    sh = be - 150 - e;
    if (sh <= 0) begin
      mant = m << (-sh);
    end else if (sh > p + 1) begin
      mant = '0;
    end else begin
      mant = m >> sh;
      g    = m[sh-1];
      if (sh > 1) st = |(m & ((64'd1 << (sh - 1)) - 64'd1));
    end
    if (g && (st || mant[0])) mant++;
    if (mant[24]) begin
      mant = mant >> 1;
      be++;
    end
    if (be >= 255) return {sgn, 8'hFF, 23'd0};
    return {sgn, mant[23] ? 8'(be) : 8'd0, mant[22:0]};
  endfunction

  function automatic bit f32_is_nan(logic [31:0] a);
    return (&a[30:23]) && (|a[22:0]);
  endfunction

  function automatic bit f32_is_inf(logic [31:0] a);
    return (&a[30:23]) && !(|a[22:0]);
  endfunction

  function automatic logic [31:0] f32_mul(logic [31:0] a, logic [31:0] b);
    logic        sgn;
    logic [23:0] ma;
    logic [23:0] mb;
    int          ea;
    int          eb;
    sgn = a[31] ^ b[31];
    ma  = {|a[30:23], a[22:0]};
    mb  = {|b[30:23], b[22:0]};
    ea  = (a[30:23] == 0) ? 1 : a[30:23];
    eb  = (b[30:23] == 0) ? 1 : b[30:23];
    if (f32_is_nan(a) || f32_is_nan(b)) return fitp_pkg::CANON_NAN;
    if ((f32_is_inf(a) && b[30:0] == 0) || (f32_is_inf(b) && a[30:0] == 0))
      return fitp_pkg::CANON_NAN;
    if (f32_is_inf(a) || f32_is_inf(b)) return {sgn, 8'hFF, 23'd0};
    if (ma == 0 || mb == 0) return {sgn, 31'd0};
    return f32_round(sgn, 64'(ma) * 64'(mb), ea + eb - 300);
  endfunction

  function automatic logic [31:0] f32_add(logic [31:0] a, logic [31:0] b);
    logic [31:0] hi;
    logic [31:0] lo;
    logic [63:0] mh;
    logic [63:0] ml;
    logic [63:0] sum;
    int          eh;
    int          el;
    if (f32_is_nan(a) || f32_is_nan(b)) return fitp_pkg::CANON_NAN;
    if (f32_is_inf(a) && f32_is_inf(b) && a[31] != b[31]) return fitp_pkg::CANON_NAN;
    if (f32_is_inf(a)) return a;
    if (f32_is_inf(b)) return b;
    if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
    if (b[30:0] > a[30:0]) begin
      hi = b;
      lo = a;
    end else begin
      hi = a;
      lo = b;
    end
    eh = (hi[30:23] == 0) ? 1 : hi[30:23];
    el = (lo[30:23] == 0) ? 1 : lo[30:23];
    mh = 64'({|hi[30:23], hi[22:0]}) << 30;
    // far below the guard bit the smaller operand only counts as sticky
    if (eh - el <= 30) ml = 64'({|lo[30:23], lo[22:0]}) << (30 - (eh - el));
    else               ml = 64'(lo[30:0] != 0);
    sum = (hi[31] == lo[31]) ? mh + ml : mh - ml;
    if (sum == 0) return 32'd0;
    return f32_round(hi[31], sum, eh - 180);
  endfunction

  // ---------------------------------------------------------------- predictor
  function automatic logic [31:0] x_of_radius(logic [31:0] r);
    return f32_add(f32_mul(f32_mul(r, r), scale_mdl), fitp_pkg::FP_TWO);
  endfunction

  function automatic logic [31:0] interp_force(logic [31:0] r);
    logic [31:0] x;
    logic [31:0] node;
    logic [31:0] dx;
    logic [8:0]  ti;
    x    = x_of_radius(r);
    ti   = x[DROP+8:DROP];
    node = {x[31:DROP], 18'd0};
    dx   = f32_add(x, {~node[31], node[30:0]});
    return f32_add(val_mdl[ti], f32_mul(dx, slope_mdl[ti]));
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic logic [31:0] rnd_float();
    case ($urandom_range(0, 7))
      0:       return $urandom;
      1:       return {1'($urandom), 8'($urandom_range(0, 2)), 23'($urandom)};
      default: return {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)};
    endcase
  endfunction

  function automatic logic [31:0] rnd_radius();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return {1'b1, 8'($urandom_range(100, 135)), 23'($urandom)};
      default: return {1'b0, 8'($urandom_range(110, 133)), 23'($urandom)};
    endcase
  endfunction

  task automatic push_load(logic [8:0] ti, logic [31:0] v, logic [31:0] s);
    beat_t b;
    b = '{fitp_pkg::OP_WRITE, ti, v, s, $urandom, 32'd0};
    val_mdl[ti]   = v;
    slope_mdl[ti] = s;
    loaded[ti]    = 1'b1;
    pending_beats.push_back(b);
  endtask

  // an evaluation never reads an unloaded entry: load it first if needed
  task automatic push_eval(logic [31:0] r);
    beat_t       b;
    logic [31:0] x;
    x = x_of_radius(r);
    if (!loaded[x[DROP+8:DROP]]) push_load(x[DROP+8:DROP], rnd_float(), rnd_float());
    b = '{fitp_pkg::OP_EVAL, 9'($urandom), $urandom, $urandom, r, 32'd0};
    b.force_exp = interp_force(r);
    pending_beats.push_back(b);
  endtask

  task automatic drain_and_set_scale(logic [31:0] sc);
    wait (pending_beats.size() == 0 && force_queue.size() == 0);
    repeat (30) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= sc;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    scale_mdl = sc;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------- clock, reset
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    logic [31:0] scales[7];
    scales = '{32'h3F80_0000, 32'h0000_0000, 32'hBF80_0000, 32'hFFFF_FFFF,
               32'h7F80_0000, 32'h0000_0001, 32'h4780_0000};
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    n_errors      = 0;
    scale_mdl     = fitp_pkg::SCALE_RESET;
    foreach (loaded[i]) loaded[i] = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: table extremes, radius corner cases, under reset scale
    push_load(9'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_load(9'h1FF, 32'h0000_0000, 32'h7F7F_FFFF);
    push_load(9'h0AA, 32'h8000_0000, 32'h0000_0001);
    push_load(9'h155, 32'h7F80_0000, 32'hFF80_0000);
    push_eval(32'h0000_0000);
    push_eval(32'h8000_0000);
    push_eval(32'hBF80_0000);
    push_eval(32'h7FC0_0000);
    push_eval(32'hFFFF_FFFF);
    push_eval(32'h7F80_0000);
    push_eval(32'h7F7F_FFFF);
    push_eval(32'h0000_0001);
    push_eval(32'h3F80_0000);
    push_eval(32'h4000_0000);
    push_eval(32'h5F80_0000);

    // random phases over the scale settings
    foreach (scales[k]) begin
      if (k > 0) drain_and_set_scale(scales[k]);
      for (int n = 0; n < 225; n++) begin
        if ($urandom_range(0, 3) == 0) push_load(9'($urandom), rnd_float(), rnd_float());
        else                            push_eval(rnd_radius());
        // keep the queue short so that idling stays tied to the bus
        while (pending_beats.size() > 8) @(posedge clk_i);
      end
    end
    drain_and_set_scale(fitp_pkg::SCALE_RESET);
    for (int n = 0; n < 40; n++) push_eval(rnd_radius());

    wait (pending_beats.size() == 0 && force_queue.size() == 0);
    repeat (40) @(posedge clk_i);
    if (n_errors == 0) $display("end of test: clean");
    else               $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------- input driver
  always @(posedge clk_i) begin
    s_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      if (pending_beats[0].op == fitp_pkg::OP_EVAL) begin
        force_queue.push_back(pending_beats[0].force_exp);
      end
      void'(pending_beats.pop_front());
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      gap_left   <= 0;
      burst_left <= 0;
    end else if (s_axis_tvalid && !s_taken) begin
      // hold the beat until it is taken
    end else if (gap_left > 0) begin
      s_axis_tvalid <= 1'b0;
      gap_left      <= gap_left - 1;
    end else if (pending_beats.size() > 0) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tuser  <= pending_beats[0].op;
      s_axis_tdata  <= {7'd0, pending_beats[0].radius, pending_beats[0].slope,
                        pending_beats[0].value, pending_beats[0].idx};
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- output stall
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      hold_left      <= 0;
      rx_mode_left   <= 0;
      rx_mode        <= 0;
      long_hold_done <= 1'b0;
    end else if (!long_hold_done && results_seen >= 150) begin
      // one long hold so that the queue fills and s_axis_tready drops
      long_hold_done <= 1'b1;
      hold_left      <= 400;
      m_axis_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= $urandom_range(0, 2);
        rx_mode_left <= $urandom_range(16, 96);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= 1'($urandom);
      endcase
    end
  end

  // ---------------------------------------------------------------- result check
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      results_seen <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      results_seen <= results_seen + 1;
      if (force_queue.size() == 0) begin
        $display("%0t: unexpected result beat, actual force_over_r %h", $time,
                 m_axis_tdata);
        n_errors++;
      end else begin
        if (m_axis_tdata !== force_queue[0]) begin
          $display("%0t: force_over_r expected %h actual %h", $time, force_queue[0],
                   m_axis_tdata);
          n_errors++;
        end
        void'(force_queue.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
